// File: sv/hufd_pkg.sv
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and constants of the tree-walk Huffman decoder: field widths,
// stream word layout, node record and the controller/datapath interface.
// ----------------------------------------------------------------------------
package hufd_pkg;

  // Field widths
  localparam int IDX_W = 9;
  localparam int SYM_W = 8;

  // Default alphabet size; the node store holds 2*SYMBOL_COUNT-1 nodes
  localparam int DEF_SYMBOL_COUNT = 256;

  // Command codes carried on in_tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Input tdata layout, lowest bit first
  localparam int NODE_IDX_LSB  = 0;
  localparam int LEFT_LSB      = NODE_IDX_LSB + IDX_W;
  localparam int RIGHT_LSB     = LEFT_LSB + IDX_W;
  localparam int SYMBOL_LSB    = RIGHT_LSB + IDX_W;
  localparam int LEAF_BIT      = SYMBOL_LSB + SYM_W;
  localparam int CODE_BIT      = LEAF_BIT + 1;
  localparam int IN_FIELDS_W   = CODE_BIT + 1;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = SYM_W;

  // One tree node as stored
  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] symbol;
    logic             leaf;
  } node_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_we;        // write the node carried by the input transfer
    logic latch_bit;      // hold the code bit of the input transfer
    logic rd_walk;        // read the node at the walk position
    logic step;           // move to a child and read it
    logic step_from_mem;  // children come from the read data, else the held node
    logic use_in_bit;     // steer by the input bit, else by the held bit
    logic capture;        // hold the read data as the current node
    logic emit_cur;       // send the held node's symbol, return to root
    logic emit_mem;       // send the read node's symbol, return to root
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cur_vld;    // held node matches the walk position
    logic cur_leaf;   // held node is a leaf
    logic mem_leaf;   // read data is a leaf
    logic slot_free;  // output register can take a symbol this cycle
  } ctl_sts_t;

endpackage

// File: sv/hufd_datapath.sv
// ----------------------------------------------------------------------------
// hufd_datapath
// Node store, walk position, root register, current-node cache and the
// output register of the tree-walk decoder.
// ----------------------------------------------------------------------------
module hufd_datapath
  import hufd_pkg::*;
#(
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input payload
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // configuration write
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_data,
  // output channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // controller link
  input  ctl_cmd_t               cmd,
  output ctl_sts_t               sts
);

  localparam int NODE_DEPTH = 2 * SYMBOL_COUNT - 1;
  localparam int ADDR_W     = $clog2(NODE_DEPTH);
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(NODE_DEPTH);
  localparam logic [SYM_W:0]   SYM_MAX   = (SYM_W+1)'(SYMBOL_COUNT - 1);

  node_t            mem [NODE_DEPTH];
  node_t            rd_data_r;
  logic             rd_oob_r;
  node_t            mem_node;

  logic [IDX_W-1:0] root_r;
  logic [IDX_W-1:0] walk_r;
  logic [IDX_W-1:0] walk_nxt;
  node_t            cur_r;
  logic             cur_vld_r;
  logic             cur_vld_nxt;
  logic             bit_r;
  logic             out_valid_r;
  logic [SYM_W-1:0] out_sym_r;

  // Unpack the load fields
  logic [IDX_W-1:0] ld_index;
  logic [SYM_W-1:0] ld_symbol;
  node_t            ld_node;
  logic             ld_in_range;

  assign ld_index    = in_tdata[NODE_IDX_LSB +: IDX_W];
  assign ld_symbol   = in_tdata[SYMBOL_LSB +: SYM_W];
  assign ld_in_range = ld_index < DEPTH_IDX;

  // Saturate symbols beyond the alphabet
  always_comb begin
    ld_node.left   = in_tdata[LEFT_LSB +: IDX_W];
    ld_node.right  = in_tdata[RIGHT_LSB +: IDX_W];
    ld_node.leaf   = in_tdata[LEAF_BIT];
    if ({1'b0, ld_symbol} > SYM_MAX) begin
      ld_node.symbol = SYM_MAX[SYM_W-1:0];
    end else begin
      ld_node.symbol = ld_symbol;
    end
  end

  // Pick the child to step to
  node_t            step_node;
  logic             step_bit;
  logic [IDX_W-1:0] child;

  assign step_node = cmd.step_from_mem ? mem_node : cur_r;
  assign step_bit  = cmd.use_in_bit ? in_tdata[CODE_BIT] : bit_r;
  assign child     = step_bit ? step_node.right : step_node.left;

  // Read address and range check
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             rd_in_range;

  assign rd_addr     = cmd.step ? child : walk_r;
  assign rd_en       = cmd.step | cmd.rd_walk;
  assign rd_in_range = rd_addr < DEPTH_IDX;

  // Node store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_we && ld_in_range) begin
      mem[ld_index[ADDR_W-1:0]] <= ld_node;
    end
    if (rd_en && rd_in_range) begin
      rd_data_r <= mem[rd_addr[ADDR_W-1:0]];
    end
    if (rd_en) begin
      rd_oob_r <= !rd_in_range;
    end
  end

  // Out-of-range reads see an empty inner node
  assign mem_node = rd_oob_r ? node_t'('0) : rd_data_r;

  // Next walk position and cache flag
  always_comb begin
    walk_nxt    = walk_r;
    cur_vld_nxt = cur_vld_r;
    if (cfg_we) begin
      walk_nxt    = cfg_data;
      cur_vld_nxt = 1'b0;
    end else if (cmd.emit_cur || cmd.emit_mem) begin
      walk_nxt    = root_r;
      cur_vld_nxt = 1'b0;
    end else if (cmd.step) begin
      walk_nxt    = child;
      cur_vld_nxt = 1'b0;
    end else if (cmd.capture) begin
      cur_vld_nxt = 1'b1;
    end else if (cmd.load_we) begin
      cur_vld_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      walk_r      <= '0;
      cur_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        root_r <= cfg_data;
      end
      walk_r    <= walk_nxt;
      cur_vld_r <= cur_vld_nxt;
      if (cmd.emit_cur || cmd.emit_mem) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_bit) begin
      bit_r <= in_tdata[CODE_BIT];
    end
    if (cmd.capture) begin
      cur_r <= mem_node;
    end
    if (cmd.emit_cur) begin
      out_sym_r <= cur_r.symbol;
    end else if (cmd.emit_mem) begin
      out_sym_r <= mem_node.symbol;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;

  assign sts.cur_vld   = cur_vld_r;
  assign sts.cur_leaf  = cur_r.leaf;
  assign sts.mem_leaf  = mem_node.leaf;
  assign sts.slot_free = !out_valid_r || out_tready;

endmodule

// File: sv/hufd_ctrl.sv
// ----------------------------------------------------------------------------
// hufd_ctrl
// Sequencer of the tree-walk decoder: takes one input transfer at a time and
// steps the datapath through node reads and symbol output.
// ----------------------------------------------------------------------------
module hufd_ctrl
  import hufd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     in_tuser,
  output ctl_cmd_t cmd,
  input  ctl_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;  // wait for an input transfer
  localparam logic [1:0] S_CUR  = 2'd1;  // read data is the walk position node
  localparam logic [1:0] S_EVAL = 2'd2;  // held node waits for output space
  localparam logic [1:0] S_NXT  = 2'd3;  // read data is the child node

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Decide commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_bit = 1'b1;
          if (in_tuser == CMD_LOAD) begin
            cmd.load_we = 1'b1;
          end else if (!sts.cur_vld) begin
            cmd.rd_walk = 1'b1;
            state_nxt   = S_CUR;
          end else if (sts.cur_leaf) begin
            if (sts.slot_free) begin
              cmd.emit_cur = 1'b1;
            end else begin
              state_nxt = S_EVAL;
            end
          end else begin
            cmd.step       = 1'b1;
            cmd.use_in_bit = 1'b1;
            state_nxt      = S_NXT;
          end
        end
      end
      S_CUR: begin
        if (sts.mem_leaf) begin
          if (sts.slot_free) begin
            cmd.emit_mem = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = S_EVAL;
          end
        end else begin
          cmd.step          = 1'b1;
          cmd.step_from_mem = 1'b1;
          state_nxt         = S_NXT;
        end
      end
      S_EVAL: begin
        if (sts.cur_leaf) begin
          if (sts.slot_free) begin
            cmd.emit_cur = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_NXT;
        end
      end
      S_NXT: begin
        if (sts.mem_leaf && sts.slot_free) begin
          cmd.emit_mem = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.mem_leaf) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end else begin
          cmd.capture = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/huffman_tree_walk_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Bit-serial Huffman decoder that walks a prefix tree held in a node store.
// ----------------------------------------------------------------------------
// Load transfers (in_tuser = 0) write one tree node. Decode transfers
// (in_tuser = 1) carry one code bit: the walk steps to the left or right
// child and, on reaching a leaf, sends the leaf's symbol and returns to the
// root. A decode bit steps straight from the current node while it is held
// in the node cache; for the first bit after reset, a symbol, a node load or
// a root write, the node at the walk position is read from the store first,
// and its symbol is sent without a step when it is itself a leaf. Each step
// needs the node chosen by the previous bit, and the store's read data is
// registered. A symbol waiting on a stalled output holds the walk until it
// is taken. Writing the root register also restarts the walk at the new
// root. Nodes must be loaded before the walk reaches them; loads beyond the
// store are dropped and symbols beyond the alphabet are clipped to its last
// symbol.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder
  import hufd_pkg::*;
#(
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [8:0] node_index, [17:9] left_child, [26:18] right_child,
  // [34:27] leaf_symbol, [35] is_leaf, [36] code_bit, [39:37] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] command
  input  logic                   in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] decoded_symbol
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // root node register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_W-1:0]       cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     cfg_we;

  // Take root writes at any time
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  hufd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

  hufd_datapath #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
